/* design/cot_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cot_pkg
// Shared constants and tables for the circle outline tessellator.
// ----------------------------------------------------------------------------
package cot_pkg;

    localparam int SEG_BITS     = 6;
    localparam int SEGMENTS     = 1 << SEG_BITS;
    localparam int FRAC_BITS    = SEG_BITS - 2;
    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 33;
    localparam int RW           = 25;
    localparam int DW           = 26;
    localparam int PW           = 2 * DW;
    localparam int SQW          = 56;
    localparam int SQ_STEPS     = SQW / 2;
    localparam int NW           = 48;
    localparam int REMW         = 30;
    localparam int ACCW         = 40;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [30:0]          HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [RW+1:0] OUT_MAX     = 27'sd16777215;
    localparam logic signed [RW+1:0] OUT_MIN     = -27'sd16777216;

    typedef logic signed [RW-1:0] coord_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] k);
        logic signed [CW-1:0] a;
        unique case (k)
            5'd0:  a = 33'sd843314857;
            5'd1:  a = 33'sd497837829;
            5'd2:  a = 33'sd263043837;
            5'd3:  a = 33'sd133525159;
            5'd4:  a = 33'sd67021687;
            5'd5:  a = 33'sd33543516;
            5'd6:  a = 33'sd16775851;
            5'd7:  a = 33'sd8388437;
            5'd8:  a = 33'sd4194283;
            5'd9:  a = 33'sd2097149;
            5'd10: a = 33'sd1048576;
            5'd11: a = 33'sd524288;
            5'd12: a = 33'sd262144;
            5'd13: a = 33'sd131072;
            5'd14: a = 33'sd65536;
            5'd15: a = 33'sd32768;
            5'd16: a = 33'sd16384;
            5'd17: a = 33'sd8192;
            5'd18: a = 33'sd4096;
            5'd19: a = 33'sd2048;
            5'd20: a = 33'sd1024;
            5'd21: a = 33'sd512;
            5'd22: a = 33'sd256;
            5'd23: a = 33'sd128;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* design/circle_outline_tessellator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_outline_tessellator
// Emits one rim point per segment of a 64-gon, and a stroke quad when stroked.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    center, radius, thickness, visibility
// m_        out  m_valid/m_ready    rim point, four corners, stroke_valid, last
//
// Each segment end point runs a 24-step CORDIC, then two multiplies on the
// shared multiplier. With the stroke on, the segment adds a 28-step square
// root and two 48-step divides. A request runs through all 64 segments;
// s_ready is high only while idle.
// Reset is synchronous, active low, and returns the sequencer to idle.
// A stalled m_ready holds the current result and the sequencer.
// ----------------------------------------------------------------------------
module circle_outline_tessellator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [15:0] s_center_x,
    input  logic signed [15:0] s_center_y,
    input  logic [13:0] s_radius,
    input  logic [15:0] s_thickness,
    input  logic        s_fill_visible,
    input  logic        s_stroke_visible,
    output logic        m_valid,
    input  logic        m_ready,
    output cot_pkg::coord_t m_rim_x,
    output cot_pkg::coord_t m_rim_y,
    output cot_pkg::coord_t m_corner_a_x,
    output cot_pkg::coord_t m_corner_a_y,
    output cot_pkg::coord_t m_corner_b_x,
    output cot_pkg::coord_t m_corner_b_y,
    output cot_pkg::coord_t m_corner_c_x,
    output cot_pkg::coord_t m_corner_c_y,
    output cot_pkg::coord_t m_corner_d_x,
    output cot_pkg::coord_t m_corner_d_y,
    output logic        m_stroke_valid,
    output logic        m_last
);
    import cot_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ZI   = 4'd1;
    localparam logic [3:0] S_CORD = 4'd2;
    localparam logic [3:0] S_ROT  = 4'd3;
    localparam logic [3:0] S_RX   = 4'd4;
    localparam logic [3:0] S_RY   = 4'd5;
    localparam logic [3:0] S_RW   = 4'd6;
    localparam logic [3:0] S_DXX  = 4'd7;
    localparam logic [3:0] S_DYY  = 4'd8;
    localparam logic [3:0] S_SQI  = 4'd9;
    localparam logic [3:0] S_SQ   = 4'd10;
    localparam logic [3:0] S_MUL  = 4'd11;
    localparam logic [3:0] S_DVI  = 4'd12;
    localparam logic [3:0] S_DV   = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    logic [3:0] state_reg;
    logic [SEG_BITS-1:0] seg_reg, idx_reg;
    logic [5:0] cnt_reg;
    logic have_start_reg, stroke_on_reg, div_y_reg, neg_reg, sv_reg;
    logic signed [15:0] cx_reg, cy_reg;
    logic [13:0] rad_reg;
    logic [15:0] thk_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic [1:0] quad_reg;
    logic signed [15:0] c_reg, s_reg;
    logic signed [PW-1:0] prod_reg;
    coord_t rx_reg, p0x_reg, p0y_reg, p1x_reg, p1y_reg;
    logic [ACCW-1:0] acc_reg;
    logic [SQW-1:0] v_reg, res_reg, bit_reg;
    logic [NW-1:0] num_reg;
    logic [REMW-1:0] rem_reg;
    logic signed [DW-1:0] ox_reg, oy_reg;

    logic signed [DW-1:0] ma, mb, dx, dy, tq;
    logic signed [PW-1:0] mprod;
    logic signed [CW-1:0] xs, ys;
    logic signed [15:0] cq, sq;
    logic [34:0] zprod;
    coord_t rim_new;
    logic signed [CW-1:0] rim_sum;
    logic [SQW-1:0] sq_t;
    logic [REMW:0] rem_sh;
    logic [REMW+1:0] diff;
    logic [REMW:0] dvs;
    logic [NW-1:0] nmag;

    function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = (v + 33'sd16384) >>> 15;
        if (r > 33'sd32767) r = 33'sd32767;
        if (r < -33'sd32767) r = -33'sd32767;
        return r[15:0];
    endfunction

    function automatic coord_t sat25(input logic signed [RW+1:0] v);
        logic signed [RW+1:0] r;
        r = v;
        if (r > OUT_MAX) r = OUT_MAX;
        if (r < OUT_MIN) r = OUT_MIN;
        return r[RW-1:0];
    endfunction

    assign dx = DW'(p1x_reg) - DW'(p0x_reg);
    assign dy = DW'(p1y_reg) - DW'(p0y_reg);
    assign tq = DW'({thk_reg, 8'd0});

    always_comb begin
        ma = DW'($signed({1'b0, rad_reg}));
        mb = DW'(c_reg);
        unique case (state_reg)
            S_RY:    mb = DW'(s_reg);
            S_DXX:   begin ma = dx; mb = dx; end
            S_DYY:   begin ma = dy; mb = dy; end
            S_MUL:   begin ma = div_y_reg ? dx : dy; mb = tq; end
            default: ;
        endcase
    end
    assign mprod = ma * mb;

    assign xs = x_reg >>> cnt_reg[4:0];
    assign ys = y_reg >>> cnt_reg[4:0];
    assign cq = to_q15(x_reg);
    assign sq = to_q15(y_reg);
    assign zprod = 35'(idx_reg[FRAC_BITS-1:0]) * 35'(HALF_PI_Q30);
    assign rim_sum = (CW'(prod_reg) + 33'sd64) >>> 7;
    assign rim_new = RW'(CW'(state_reg == S_RY ? cx_reg : cy_reg) * 33'sd256 + rim_sum);

    assign sq_t = res_reg + bit_reg;
    assign dvs = {res_reg[REMW-1:0], 1'b0};
    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign diff = {1'b0, rem_sh} - {1'b0, dvs};
    assign nmag = prod_reg[PW-1] ? NW'(-prod_reg) : NW'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            seg_reg <= '0;
            idx_reg <= '0;
            cnt_reg <= '0;
            have_start_reg <= 1'b0;
            div_y_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cx_reg <= s_center_x;
                        cy_reg <= s_center_y;
                        rad_reg <= s_radius;
                        thk_reg <= s_thickness;
                        stroke_on_reg <= (s_thickness != 16'd0) && s_stroke_visible
                                         && (s_radius != 14'd0);
                        seg_reg <= '0;
                        idx_reg <= '0;
                        have_start_reg <= 1'b0;
                        if (s_fill_visible || ((s_thickness != 16'd0) && s_stroke_visible
                                               && (s_radius != 14'd0))) begin
                            state_reg <= S_ZI;
                        end
                    end
                end
                S_ZI: begin
                    x_reg <= CORDIC_GAIN;
                    y_reg <= '0;
                    z_reg <= CW'(zprod >> FRAC_BITS);
                    quad_reg <= idx_reg[SEG_BITS-1:SEG_BITS-2];
                    cnt_reg <= '0;
                    state_reg <= S_CORD;
                end
                S_CORD: begin
                    if (!z_reg[CW-1]) begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - atan_q30(cnt_reg[4:0]);
                    end else begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + atan_q30(cnt_reg[4:0]);
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(CORDIC_STEPS - 1)) state_reg <= S_ROT;
                end
                S_ROT: begin
                    unique case (quad_reg)
                        2'd0: begin c_reg <= cq; s_reg <= sq; end
                        2'd1: begin c_reg <= -sq; s_reg <= cq; end
                        2'd2: begin c_reg <= -cq; s_reg <= -sq; end
                        default: begin c_reg <= sq; s_reg <= -cq; end
                    endcase
                    state_reg <= S_RX;
                end
                S_RX: begin
                    prod_reg <= mprod;
                    state_reg <= S_RY;
                end
                S_RY: begin
                    prod_reg <= mprod;
                    rx_reg <= rim_new;
                    state_reg <= S_RW;
                end
                S_RW: begin
                    sv_reg <= 1'b0;
                    if (!have_start_reg) begin
                        p0x_reg <= rx_reg;
                        p0y_reg <= rim_new;
                        have_start_reg <= 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_ZI;
                    end else begin
                        p1x_reg <= rx_reg;
                        p1y_reg <= rim_new;
                        state_reg <= stroke_on_reg ? S_DXX : S_OUT;
                    end
                end
                S_DXX: begin
                    prod_reg <= mprod;
                    state_reg <= S_DYY;
                end
                S_DYY: begin
                    acc_reg <= prod_reg[ACCW-1:0];
                    prod_reg <= mprod;
                    state_reg <= S_SQI;
                end
                S_SQI: begin
                    v_reg <= {acc_reg + prod_reg[ACCW-1:0], 16'd0};
                    res_reg <= '0;
                    bit_reg <= SQW'(1) << (SQW - 2);
                    cnt_reg <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ: begin
                    if (v_reg >= sq_t) begin
                        v_reg <= v_reg - sq_t;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(SQ_STEPS - 1)) begin
                        div_y_reg <= 1'b0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (res_reg == '0) begin
                        state_reg <= S_OUT;
                    end else begin
                        prod_reg <= mprod;
                        state_reg <= S_DVI;
                    end
                end
                S_DVI: begin
                    // the x offset negates dy*t
                    neg_reg <= div_y_reg ? prod_reg[PW-1]
                                         : (!prod_reg[PW-1] && prod_reg != '0);
                    num_reg <= nmag + res_reg[NW-1:0];
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= S_DV;
                end
                S_DV: begin
                    num_reg <= {num_reg[NW-2:0], ~diff[REMW+1]};
                    rem_reg <= diff[REMW+1] ? rem_sh[REMW-1:0] : diff[REMW-1:0];
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(NW - 1)) begin
                        if (div_y_reg) begin
                            oy_reg <= neg_reg ? -DW'({num_reg[NW-2:0], ~diff[REMW+1]})
                                              : DW'({num_reg[NW-2:0], ~diff[REMW+1]});
                            sv_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            ox_reg <= neg_reg ? -DW'({num_reg[NW-2:0], ~diff[REMW+1]})
                                              : DW'({num_reg[NW-2:0], ~diff[REMW+1]});
                            div_y_reg <= 1'b1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        if (seg_reg == SEG_BITS'(SEGMENTS - 1)) begin
                            state_reg <= S_IDLE;
                        end else begin
                            seg_reg <= seg_reg + 1'b1;
                            idx_reg <= seg_reg + SEG_BITS'(2);
                            p0x_reg <= p1x_reg;
                            p0y_reg <= p1y_reg;
                            state_reg <= S_ZI;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_rim_x = p0x_reg;
    assign m_rim_y = p0y_reg;
    assign m_stroke_valid = sv_reg;
    assign m_last = (seg_reg == SEG_BITS'(SEGMENTS - 1));
    assign m_corner_a_x = sv_reg ? sat25((RW+2)'(p0x_reg) + (RW+2)'(ox_reg)) : '0;
    assign m_corner_a_y = sv_reg ? sat25((RW+2)'(p0y_reg) + (RW+2)'(oy_reg)) : '0;
    assign m_corner_b_x = sv_reg ? sat25((RW+2)'(p0x_reg) - (RW+2)'(ox_reg)) : '0;
    assign m_corner_b_y = sv_reg ? sat25((RW+2)'(p0y_reg) - (RW+2)'(oy_reg)) : '0;
    assign m_corner_c_x = sv_reg ? sat25((RW+2)'(p1x_reg) - (RW+2)'(ox_reg)) : '0;
    assign m_corner_c_y = sv_reg ? sat25((RW+2)'(p1y_reg) - (RW+2)'(oy_reg)) : '0;
    assign m_corner_d_x = sv_reg ? sat25((RW+2)'(p1x_reg) + (RW+2)'(ox_reg)) : '0;
    assign m_corner_d_y = sv_reg ? sat25((RW+2)'(p1y_reg) + (RW+2)'(oy_reg)) : '0;

endmodule

/* dv/circle_outline_tessellator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_outline_tessellator_tb
// Drives circle requests through valid/ready with random bursts and gaps.
// A scoreboard class predicts every 64-gon segment: CORDIC trig, rim point,
// square root and stroke offsets. It checks each result field by field in
// order. The receiver stalls at random, and once for a long stretch.
// ----------------------------------------------------------------------------
module circle_outline_tessellator_tb;
    import cot_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 3000;
    localparam int RANDOM_ITEMS   = 120;

    typedef struct {
        coord_t rim_x, rim_y;
        coord_t a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y;
        logic   stroke_valid, last;
    } segment_t;

    class tessellation_board;
        segment_t   pending[$];
        int         errors;
        longint     cos_tab[SEGMENTS];
        longint     sin_tab[SEGMENTS];
        longint     atan_tab[24] = '{843314857, 497837829, 263043837, 133525159,
            67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
            524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048,
            1024, 512, 256, 128};

        function new();
            for (int i = 0; i < SEGMENTS; i++) begin
                build_trig(i);
            end
        endfunction

        function longint q15(longint v);
            longint r;
            r = (v + 16384) >>> 15;
            if (r > 32767) r = 32767;
            if (r < -32767) r = -32767;
            return r;
        endfunction

        function void build_trig(int i);
            longint p, z, x, y, xs, ys, cq, sq;
            int quad;
            p = (longint'(i) << 24) / SEGMENTS;
            quad = int'((p >> 22) & 3);
            z = ((p & 64'h3FFFFF) * 1686629713) >> 22;
            x = 652032874;
            y = 0;
            for (int k = 0; k < 24; k++) begin
                xs = x >>> k;
                ys = y >>> k;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= atan_tab[k];
                end else begin
                    x += ys; y -= xs; z += atan_tab[k];
                end
            end
            cq = q15(x);
            sq = q15(y);
            case (quad)
                0: begin cos_tab[i] = cq;  sin_tab[i] = sq;  end
                1: begin cos_tab[i] = -sq; sin_tab[i] = cq;  end
                2: begin cos_tab[i] = -cq; sin_tab[i] = -sq; end
                default: begin cos_tab[i] = sq; sin_tab[i] = -cq; end
            endcase
        endfunction

        function longint root(logic [63:0] v);
            logic [63:0] res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return longint'(res);
        endfunction

        function longint half_up_div(longint n, longint d);
            longint m, q;
            m = (n < 0) ? -n : n;
            q = (m + d / 2) / d;
            return (n < 0) ? -q : q;
        endfunction

        function coord_t clamp(longint v);
            if (v > 16777215) v = 16777215;
            if (v < -16777216) v = -16777216;
            return coord_t'(v);
        endfunction

        function void note_request(logic signed [15:0] cx, logic signed [15:0] cy,
                                   logic [13:0] rad, logic [15:0] thick,
                                   logic fill, logic strk);
            longint x0, y0, x1, y1, dx, dy, len, t, ox, oy;
            bit stroke_on;
            segment_t s;
            stroke_on = thick != 0 && strk && rad != 0;
            if (!fill && !stroke_on) return;
            for (int i = 0; i < SEGMENTS; i++) begin
                x0 = longint'(cx) * 256 + ((longint'(rad) * cos_tab[i] + 64) >>> 7);
                y0 = longint'(cy) * 256 + ((longint'(rad) * sin_tab[i] + 64) >>> 7);
                x1 = longint'(cx) * 256
                     + ((longint'(rad) * cos_tab[(i + 1) % SEGMENTS] + 64) >>> 7);
                y1 = longint'(cy) * 256
                     + ((longint'(rad) * sin_tab[(i + 1) % SEGMENTS] + 64) >>> 7);
                s = '{default: '0};
                s.rim_x = coord_t'(x0);
                s.rim_y = coord_t'(y0);
                if (stroke_on) begin
                    dx = x1 - x0;
                    dy = y1 - y0;
                    len = root(64'(dx * dx + dy * dy) << 16);
                    if (len != 0) begin
                        t = longint'(thick) * 256;
                        ox = half_up_div(-dy * t, 2 * len);
                        oy = half_up_div(dx * t, 2 * len);
                        s.a_x = clamp(x0 + ox); s.a_y = clamp(y0 + oy);
                        s.b_x = clamp(x0 - ox); s.b_y = clamp(y0 - oy);
                        s.c_x = clamp(x1 - ox); s.c_y = clamp(y1 - oy);
                        s.d_x = clamp(x1 + ox); s.d_y = clamp(y1 + oy);
                        s.stroke_valid = 1'b1;
                    end
                end
                s.last = (i == SEGMENTS - 1);
                pending.insert(pending.size(), s);
            end
        endfunction

        function void field(string name, longint e, longint a);
            if (e != a) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_segment(segment_t got);
            segment_t e;
            if (pending.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = pending.pop_front();
            field("rim_x", e.rim_x, got.rim_x);
            field("rim_y", e.rim_y, got.rim_y);
            field("corner_a_x", e.a_x, got.a_x);
            field("corner_a_y", e.a_y, got.a_y);
            field("corner_b_x", e.b_x, got.b_x);
            field("corner_b_y", e.b_y, got.b_y);
            field("corner_c_x", e.c_x, got.c_x);
            field("corner_c_y", e.c_y, got.c_y);
            field("corner_d_x", e.d_x, got.d_x);
            field("corner_d_y", e.d_y, got.d_y);
            field("stroke_valid", e.stroke_valid, got.stroke_valid);
            field("last", e.last, got.last);
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_center_x = '0;
    logic signed [15:0] s_center_y = '0;
    logic [13:0] s_radius = '0;
    logic [15:0] s_thickness = '0;
    logic s_fill_visible = 1'b0;
    logic s_stroke_visible = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    coord_t m_rim_x, m_rim_y, m_corner_a_x, m_corner_a_y, m_corner_b_x, m_corner_b_y;
    coord_t m_corner_c_x, m_corner_c_y, m_corner_d_x, m_corner_d_y;
    logic m_stroke_valid, m_last;

    tessellation_board board = new();
    int idle_cycles = 0;
    int segments_seen = 0;
    int burst_left = 0;

    always #5 aclk = ~aclk;

    circle_outline_tessellator dut (.*);

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            board.note_request(s_center_x, s_center_y, s_radius, s_thickness,
                               s_fill_visible, s_stroke_visible);
        end
        if (aresetn && m_valid && m_ready) begin
            board.check_segment('{m_rim_x, m_rim_y, m_corner_a_x, m_corner_a_y,
                m_corner_b_x, m_corner_b_y, m_corner_c_x, m_corner_c_y,
                m_corner_d_x, m_corner_d_y, m_stroke_valid, m_last});
            segments_seen++;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stall pattern, one long hold after some traffic
    initial begin
        int mode;
        bit held;
        held = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!held && segments_seen >= 200) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 40)) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    task automatic send_request(logic signed [15:0] cx, logic signed [15:0] cy,
                                logic [13:0] rad, logic [15:0] thick,
                                logic fill, logic strk);
        s_valid <= 1'b1;
        s_center_x <= cx;
        s_center_y <= cy;
        s_radius <= rad;
        s_thickness <= thick;
        s_fill_visible <= fill;
        s_stroke_visible <= strk;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            burst_left = $urandom_range(0, 5);
        end
    endtask

    task automatic send_random();
        logic [13:0] rad;
        logic [15:0] thick;
        logic fill, strk;
        rad = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 20)) : 14'($urandom);
        thick = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
        strk = ($urandom_range(0, 4) != 0);
        fill = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 19) == 0) begin
            fill = 1'b0;
            strk = 1'b0;
        end
        send_request(16'($urandom), 16'($urandom), rad, thick, fill, strk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_request(16'sd0, 16'sd0, 14'd100, 16'h0100, 1'b1, 1'b1);
        send_request(16'sh7FFF, 16'sh7FFF, 14'h3FFF, 16'hFFFF, 1'b1, 1'b1);
        send_request(-16'sh8000, -16'sh8000, 14'h3FFF, 16'hFFFF, 1'b0, 1'b1);
        send_request(16'sh7FFF, -16'sh8000, 14'h3FFF, 16'h0001, 1'b1, 1'b1);
        send_request(16'sd10, 16'sd20, 14'd0, 16'h0200, 1'b1, 1'b1);
        send_request(16'sd10, 16'sd20, 14'd0, 16'h0200, 1'b0, 1'b1);
        send_request(16'sd5, 16'sd5, 14'd50, 16'd0, 1'b1, 1'b1);
        send_request(16'sd5, 16'sd5, 14'd50, 16'd0, 1'b0, 1'b1);
        send_request(16'sd5, 16'sd5, 14'd50, 16'h0300, 1'b1, 1'b0);
        send_request(16'sd5, 16'sd5, 14'd50, 16'h0300, 1'b0, 1'b0);
        send_request(-16'sd3, 16'sd7, 14'd1, 16'h0080, 1'b0, 1'b1);
        send_request(16'sd0, 16'sd0, 14'd2, 16'hFFFF, 1'b1, 1'b1);
        send_request(16'sh5555, 16'shAAAA, 14'h2AAA, 16'h5555, 1'b1, 1'b1);
        send_request(16'shAAAA, 16'sh5555, 14'h1555, 16'hAAAA, 1'b0, 1'b1);
        repeat (RANDOM_ITEMS) send_random();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
